### src/assert_macros.svh
// Assertion helpers included by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PWAS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define PWAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define PWAS_ASSERT(lbl, clk, rstn, prop, msg)

`define PWAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### src/pwas_pkg.sv
package pwas_pkg;

    localparam int WINDOW_MAX_DEF = 64;

    localparam int HR_W     = 8;
    localparam int HR_MAX   = 255;
    localparam int FRAC_W   = 8;
    localparam int AVG_W    = 16;
    localparam int STRESS_W = 9;
    localparam int REF_W    = 8;
    localparam int LEN_W    = 7;
    localparam int SPAN_W   = 8;

    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_SEL_BIT = 2;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - AVG_W - STRESS_W - REF_W;

    localparam logic [REF_W-1:0]    REF_RESET  = 8'd70;
    localparam logic [SPAN_W-1:0]   SPAN_RESET = 8'd15;
    localparam logic [STRESS_W-1:0] STRESS_MAX = 9'd256;

    typedef enum logic [0:0] {
        REG_LEN  = 1'b0,
        REG_SPAN = 1'b1
    } t_reg_idx;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_CAL    = 1'b1
    } t_req;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [SPAN_W-1:0] span;
        logic              clr;
    } t_cfg;

endpackage

### src/pwas_ram.sv
module pwas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/pwas_div.sv
module pwas_div import pwas_pkg::*; #(
    parameter int DW = 22,
    parameter int VW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [VW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW-1:0] r_div, n_div;
    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          ge;

    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        diff    = shifted - {1'b0, r_div};
        ge      = (shifted >= {1'b0, r_div});

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[VW-1:0] : shifted[VW-1:0];
            n_quo = {r_quo[DW-2:0], ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### src/pwas_apb.sv
module pwas_apb import pwas_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [LEN_W-1:0]  r_len, n_len;
    logic [SPAN_W-1:0] r_span, n_span;
    logic              wr;
    logic              clr;
    t_reg_idx          idx;
    logic [LEN_W-1:0]  wlen;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[REG_SEL_BIT]);
    assign wr     = psel && penable && pwrite;
    assign wlen   = pwdata[LEN_W-1:0];

    always_comb begin
        n_len  = r_len;
        n_span = r_span;
        clr    = 1'b0;
        if (wr) begin
            case (idx)
                REG_LEN: begin
                    n_len = (int'(wlen) > WINDOW_MAX) ? LEN_W'(WINDOW_MAX) : wlen;
                    clr   = 1'b1;
                end
                REG_SPAN: begin
                    n_span = pwdata[SPAN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LEN:  prdata = APB_DW'(r_len);
            REG_SPAN: prdata = APB_DW'(r_span);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_span <= SPAN_RESET;
        end else begin
            r_len  <= n_len;
            r_span <= n_span;
        end
    end

    assign o_cfg.len  = r_len;
    assign o_cfg.span = r_span;
    assign o_cfg.clr  = clr;

endmodule

### src/pulse_window_average_stress_core.sv
// The shared bit-serial divider runs at most once for the mean and at most once for the
// stress of a sample beat, and at most once for the stress of a calibrate beat; one beat
// is in work at a time, and the next is taken while the finished result still waits in
// the output register.
// Reset is synchronous and active low: the ring reads as empty, the reference is 70,
// the span 15 and the length 0; writing the length empties the ring at once.
`include "assert_macros.svh"

module pulse_window_average_stress_core import pwas_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // heart_rate[7:0]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // req_type[0]
    input  logic                   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // average_q8[15:0], stress_q8[24:16], reference_out[32:25], zeros[39:33]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // avg_valid[0]
    output logic                   o_m_axis_tuser,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int POS_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W  = $clog2(HR_MAX * WINDOW_MAX + 1);
    localparam int DIV_DW = SUM_W + FRAC_W;
    localparam int DIV_VW = (CNT_W > SPAN_W) ? CNT_W : SPAN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_CAL,
        S_MEAN,
        S_MWAIT,
        S_STR,
        S_SWAIT,
        S_OUT
    } t_state;

    t_cfg cfg;

    t_state              r_state, n_state;
    logic [HR_W-1:0]     r_hr, n_hr;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_wrapped, n_wrapped;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [AVG_W-1:0]    r_mean, n_mean;
    logic [REF_W-1:0]    r_ref, n_ref;
    logic [STRESS_W-1:0] r_stress, n_stress;
    logic                r_out_valid, n_out_valid;
    logic [AVG_W-1:0]    r_out_avg, n_out_avg;
    logic                r_out_flag, n_out_flag;
    logic [STRESS_W-1:0] r_out_stress, n_out_stress;
    logic [REF_W-1:0]    r_out_ref, n_out_ref;

    logic                s_acc;
    logic                m_acc;
    logic [CNT_W-1:0]    len;
    logic [CNT_W-1:0]    pos_inc;
    logic [HR_W-1:0]     old;
    logic [AVG_W-1:0]    refq;

    logic                ram_we;
    logic [HR_W-1:0]     ram_rdata;

    logic                div_start;
    logic [DIV_DW-1:0]   div_dividend;
    logic [DIV_VW-1:0]   div_divisor;
    logic                div_done;
    logic [DIV_DW-1:0]   div_quo;

    pwas_apb #(
        .WINDOW_MAX(WINDOW_MAX)
    ) u_apb (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg)
    );

    pwas_ram #(
        .WIDTH(HR_W),
        .DEPTH(WINDOW_MAX)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_pos),
        .i_wdata(r_hr),
        .i_re   (s_acc),
        .i_raddr(r_pos),
        .o_rdata(ram_rdata)
    );

    pwas_div #(
        .DW(DIV_DW),
        .VW(DIV_VW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc           = r_out_valid && i_m_axis_tready;
    assign len             = CNT_W'(cfg.len);
    assign pos_inc         = CNT_W'(r_pos) + CNT_W'(1);
    assign old             = r_wrapped ? ram_rdata : '0;
    assign refq            = {r_ref, {FRAC_W{1'b0}}};

    always_comb begin
        n_state      = r_state;
        n_hr         = r_hr;
        n_pos        = r_pos;
        n_wrapped    = r_wrapped;
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        n_mean       = r_mean;
        n_ref        = r_ref;
        n_stress     = r_stress;
        n_out_valid  = m_acc ? 1'b0 : r_out_valid;
        n_out_avg    = r_out_avg;
        n_out_flag   = r_out_flag;
        n_out_stress = r_out_stress;
        n_out_ref    = r_out_ref;
        ram_we       = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_hr = i_s_axis_tdata[HR_W-1:0];
                    if (i_s_axis_tuser == REQ_CAL) begin
                        n_state = S_CAL;
                    end else if (len != '0) begin
                        n_state = S_UPD;
                    end else begin
                        n_state = S_MEAN;
                    end
                end
            end
            S_UPD: begin
                ram_we = 1'b1;
                n_sum  = r_sum - SUM_W'(old) + SUM_W'(r_hr);
                n_cnt  = r_cnt - CNT_W'(old != '0) + CNT_W'(r_hr != '0);
                if (pos_inc >= len) begin
                    n_pos     = '0;
                    n_wrapped = 1'b1;
                end else begin
                    n_pos = pos_inc[POS_W-1:0];
                end
                n_state = S_MEAN;
            end
            S_CAL: begin
                if (r_cnt != '0) begin
                    n_ref = r_mean[AVG_W-1:FRAC_W];
                end
                n_state = S_STR;
            end
            S_MEAN: begin
                if (len != '0 && r_cnt != '0) begin
                    div_start    = 1'b1;
                    div_dividend = {r_sum, {FRAC_W{1'b0}}};
                    div_divisor  = DIV_VW'(r_cnt);
                    n_state      = S_MWAIT;
                end else begin
                    n_mean  = '0;
                    n_state = S_STR;
                end
            end
            S_MWAIT: begin
                if (div_done) begin
                    n_mean  = div_quo[AVG_W-1:0];
                    n_state = S_STR;
                end
            end
            S_STR: begin
                if (r_mean <= refq) begin
                    n_stress = '0;
                    n_state  = S_OUT;
                end else if (cfg.span == '0) begin
                    n_stress = STRESS_MAX;
                    n_state  = S_OUT;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DIV_DW'(r_mean - refq);
                    div_divisor  = DIV_VW'(cfg.span);
                    n_state      = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (div_done) begin
                    n_stress = (div_quo > DIV_DW'(STRESS_MAX)) ? STRESS_MAX
                                                               : div_quo[STRESS_W-1:0];
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_avg    = r_mean;
                    n_out_flag   = (r_cnt != '0);
                    n_out_stress = r_stress;
                    n_out_ref    = r_ref;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg.clr) begin
            n_pos     = '0;
            n_wrapped = 1'b0;
            n_sum     = '0;
            n_cnt     = '0;
            n_mean    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hr         <= n_hr;
        r_stress     <= n_stress;
        r_out_avg    <= n_out_avg;
        r_out_flag   <= n_out_flag;
        r_out_stress <= n_out_stress;
        r_out_ref    <= n_out_ref;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_wrapped   <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_mean      <= '0;
            r_ref       <= REF_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_wrapped   <= n_wrapped;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_mean      <= n_mean;
            r_ref       <= n_ref;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_ref, r_out_stress, r_out_avg};
    assign o_m_axis_tuser  = r_out_flag;

    `PWAS_ASSERT(a_cnt_le_len, i_clk, i_rst_n, r_cnt <= len, "nonzero count exceeds length")
    `PWAS_ASSERT(a_sum_empty, i_clk, i_rst_n, (r_cnt == '0) |-> (r_sum == '0), "sum without count")
    `PWAS_ASSERT_NEXT(a_one_beat, i_clk, i_rst_n, s_acc, !o_s_axis_tready, "beat taken while busy")
    `PWAS_ASSERT(a_stress_max, i_clk, i_rst_n,
                 r_out_valid |-> (r_out_stress <= STRESS_MAX), "stress above one")
    `PWAS_ASSERT(a_flag_mean, i_clk, i_rst_n,
                 (r_out_valid && !r_out_flag) |-> (r_out_avg == '0), "invalid mean not zero")

endmodule
